// File: hw/rtl/edan_pkg.sv
// Shared types and constants for the echo distance average and notify unit.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package edan_pkg;

  localparam int unsigned EchoW   = 16;
  localparam int unsigned NowW    = 32;
  localparam int unsigned DistW   = 19;
  localparam int unsigned IntvW   = 16;
  localparam int unsigned ScaleW  = 12;
  localparam int unsigned ProdW   = EchoW + ScaleW;
  localparam int unsigned RawFrac = 8;
  localparam int unsigned ApbDataW = 32;
  localparam int unsigned ApbAddrW = 4;

  localparam logic [DistW-1:0]  RawMax          = {DistW{1'b1}};
  localparam logic [DistW-1:0]  ThresholdReset  = DistW'(7680);
  localparam logic [IntvW-1:0]  IntervalReset   = IntvW'(1000);
  localparam logic [ScaleW-1:0] ScaleReset      = ScaleW'(1114);

  typedef enum logic [1:0] {
    REG_NEAR_THRESHOLD  = 2'd0,
    REG_NOTIFY_INTERVAL = 2'd1,
    REG_SPEED_SCALE     = 2'd2
  } reg_idx_e;

endpackage

// File: hw/rtl/echo_distance_average_notify_unit.sv
// Echo distance unit: converts echo time to distance, averages it over a window and raises
// a rate-limited notify flag. The block takes one item per clock cycle unless back-pressure
// from m_axis_tready stalls the pipeline; each item passes through the product, sum, divide
// and output registers in turn. The running-sum update and the last-notify timer each feed
// back on their own register, which sets that rate. The window is a chain of WINDOW sample
// cells that shifts once per item and starts as all zeros. Depends on edan_pkg and edan_cell.
`timescale 1ns / 1ps

module echo_distance_average_notify_unit
  import edan_pkg::*;
#(
  parameter int unsigned WINDOW = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // APB configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  // Input items
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [47:0]         s_axis_tdata,  // echo_us[15:0], now_ms[47:16]
  input  logic                s_axis_tuser,  // link_up
  // Result items
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [39:0]         m_axis_tdata,  // raw_distance[18:0], smooth_distance[37:19]
  output logic                m_axis_tuser   // send_now
);

  localparam int unsigned LogW      = $clog2(WINDOW);
  localparam int unsigned SumW      = DistW + LogW;
  localparam int unsigned RecipW    = SumW + 1;
  localparam int unsigned QProdW    = SumW + RecipW;
  localparam int unsigned QShift    = SumW + LogW;
  localparam logic [63:0] RecipFull = ((64'd1 << QShift) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RecipW-1:0] Recip = RecipFull[RecipW-1:0];

  // Configuration registers
  logic [DistW-1:0]  thr_q;
  logic [IntvW-1:0]  intv_q;
  logic [ScaleW-1:0] scale_q;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= ThresholdReset;
      intv_q  <= IntervalReset;
      scale_q <= ScaleReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_NEAR_THRESHOLD:  thr_q   <= pwdata[DistW-1:0];
        REG_NOTIFY_INTERVAL: intv_q  <= pwdata[IntvW-1:0];
        REG_SPEED_SCALE:     scale_q <= pwdata[ScaleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_NEAR_THRESHOLD:  prdata = ApbDataW'(thr_q);
      REG_NOTIFY_INTERVAL: prdata = ApbDataW'(intv_q);
      REG_SPEED_SCALE:     prdata = ApbDataW'(scale_q);
      default:             prdata = '0;
    endcase
  end

  // Pipeline handshake
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4;
  logic ld1, ld2, ld3, ld4;

  assign rdy4 = !v4_q || m_axis_tready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready = rdy1;

  assign ld1 = s_axis_tvalid && rdy1;
  assign ld2 = v1_q && rdy2;
  assign ld3 = v2_q && rdy3;
  assign ld4 = v3_q && rdy4;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: echo time times speed scale
  logic [ProdW-1:0] prod1_q;
  logic [NowW-1:0]  now1_q;
  logic             link1_q;

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      prod1_q <= ProdW'(s_axis_tdata[EchoW-1:0]) * ProdW'(scale_q);
      now1_q  <= s_axis_tdata[EchoW +: NowW];
      link1_q <= s_axis_tuser;
    end
  end

  // Stage 2: saturate, shift the window chain and update the running sum
  logic [ProdW-RawFrac-1:0] raw_wide;
  logic [DistW-1:0]         raw;
  logic [DistW-1:0]         chain [WINDOW+1];
  logic [SumW-1:0]          sum_q;
  logic [SumW-1:0]          sum_d;
  logic [DistW-1:0]         raw2_q;
  logic [NowW-1:0]          now2_q;
  logic                     link2_q;

  assign raw_wide = prod1_q[ProdW-1:RawFrac];
  assign raw      = raw_wide[DistW] ? RawMax : raw_wide[DistW-1:0];
  assign chain[0] = raw;

  for (genvar k = 0; k < WINDOW; k++) begin : g_cell
    edan_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .shift_i  (ld2),
      .sample_i (chain[k]),
      .sample_o (chain[k+1])
    );
  end

  assign sum_d = sum_q - SumW'(chain[WINDOW]) + SumW'(raw);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (ld2) begin
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      raw2_q  <= raw;
      now2_q  <= now1_q;
      link2_q <= link1_q;
    end
  end

  // Stage 3: divide the sum by the window through a reciprocal product
  logic [QProdW-1:0] qprod3_q;
  logic [DistW-1:0]  raw3_q;
  logic [NowW-1:0]   now3_q;
  logic              link3_q;

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      qprod3_q <= QProdW'(sum_q) * QProdW'(Recip);
      raw3_q   <= raw2_q;
      now3_q   <= now2_q;
      link3_q  <= link2_q;
    end
  end

  // Stage 4: threshold and notify timer, output register
  logic [DistW-1:0] smooth;
  logic [NowW-1:0]  elapsed;
  logic             send;
  logic [NowW-1:0]  last_send_q;
  logic [DistW-1:0] raw4_q;
  logic [DistW-1:0] smooth4_q;
  logic             send4_q;

  assign smooth  = qprod3_q[QShift +: DistW];
  assign elapsed = now3_q - last_send_q;
  assign send    = link3_q && (smooth < thr_q) && (elapsed >= NowW'(intv_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_send_q <= '0;
    end else if (ld4 && send) begin
      last_send_q <= now3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld4) begin
      raw4_q    <= raw3_q;
      smooth4_q <= smooth;
      send4_q   <= send;
    end
  end

  assign m_axis_tvalid = v4_q;
  assign m_axis_tdata  = {2'b00, smooth4_q, raw4_q};
  assign m_axis_tuser  = send4_q;

endmodule

// File: hw/rtl/edan_cell.sv
// One sample cell of the averaging window shift chain.
// Depends on edan_pkg for the distance width.
`timescale 1ns / 1ps

module edan_cell
  import edan_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic [DistW-1:0] sample_i,
  output logic [DistW-1:0] sample_o
);

  logic [DistW-1:0] sample_q;
  logic [DistW-1:0] sample_d;

  assign sample_d = shift_i ? sample_i : sample_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_q <= '0;
    end else begin
      sample_q <= sample_d;
    end
  end

  assign sample_o = sample_q;

endmodule

// File: hw/rtl/edan_checker.sv
// Port-level checker for the echo distance unit, attached by a bind statement.
// Depends on edan_pkg and on the top level echo_distance_average_notify_unit.
`timescale 1ns / 1ps

module edan_checker
  import edan_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pready,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A result that waits keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // The pipeline never holds back input while the output side is draining.
  a_no_stall_when_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output ready");

  // An empty output register means the pipeline can advance.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready && pready)
    else $error("input stalled with empty output");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

endmodule

bind echo_distance_average_notify_unit edan_checker u_edan_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .pready        (pready),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
